// ===== rtl/tswr_pkg.sv =====
// Package for the TCP sender window and retransmission block.
// Holds the descriptor and result types, register indexes, reset values and
// the sequencer state type. Depends on nothing.
package tswr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned MAX_SEG_DEF     = 63;
  localparam int unsigned SEG_CNT_W       = 6;   // holds up to 63 segments per push
  localparam int unsigned ADDR_W          = 4;

  localparam logic [31:0] INITIAL_SEQ_RST = 32'd0;
  localparam logic [31:0] INITIAL_RTO_RST = 32'd1000;
  localparam logic [11:0] SEG_SIZE_RST    = 12'd1000;
  localparam logic [7:0]  MAX_RETX_RST    = 8'd8;

  localparam logic [1:0] REG_INITIAL_SEQ = 2'd0;
  localparam logic [1:0] REG_INITIAL_RTO = 2'd1;
  localparam logic [1:0] REG_SEG_SIZE    = 2'd2;
  localparam logic [1:0] REG_MAX_RETX    = 2'd3;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  typedef struct packed {
    logic        rst;
    logic        fin;
    logic        syn;
    logic [11:0] len;
  } desc_t;

  typedef struct packed {
    logic [63:0] start;
    desc_t       desc;
  } entry_t;

  typedef struct packed {
    logic        is_segment;
    logic        is_retransmit;
    logic [31:0] wire_seqno;
    logic [63:0] absolute_seqno;
    logic        syn_bit;
    logic        fin_bit;
    logic        rst_bit;
    logic [11:0] payload_len;
    logic        raise_stream_error;
    logic [31:0] in_flight;
    logic [7:0]  retx_count;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_INIT,
    ST_PUSH_SEG,
    ST_ACK_CHECK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_ACK_DONE,
    ST_TICK_ADD,
    ST_TICK_CMP,
    ST_TICK_SEND,
    ST_STATUS
  } state_e;

  function automatic logic [12:0] seq_len(input desc_t d);
    seq_len = {1'b0, d.len} + {12'd0, d.syn} + {12'd0, d.fin};
  endfunction

endpackage

// ===== rtl/tcp_sender_window_retransmit.sv =====
// TCP sender control on segment descriptors. A push sends the SYN first, or else cuts
// segments into the open window (at most 63 per push), stopping after one that carries
// FIN; an ack retires descriptors one by one through a head read of the queue memory;
// a tick runs the timer and may resend the head. Beats are registered and the
// status beat shows in the first idle cycle; one item at a time, results cannot stall.
// Reset clears all control state at once; queue contents stay undefined until written.
module tcp_sender_window_retransmit #(
  parameter int unsigned QUEUE_DEPTH           = tswr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_SEGMENTS_PER_PUSH = tswr_pkg::MAX_SEG_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  cmd_i,
  input  logic [31:0]                 bytes_available_i,
  input  logic                        stream_closed_i,
  input  logic                        stream_error_i,
  input  logic                        ack_present_i,
  input  logic [31:0]                 ack_number_i,
  input  logic [15:0]                 window_size_i,
  input  logic                        reset_flag_i,
  input  logic [31:0]                 elapsed_ms_i,
  // result channel
  output logic                        result_valid_o,
  output logic                        is_segment_o,
  output logic                        is_retransmit_o,
  output logic [31:0]                 wire_seqno_o,
  output logic [63:0]                 absolute_seqno_o,
  output logic                        syn_bit_o,
  output logic                        fin_bit_o,
  output logic                        rst_bit_o,
  output logic [11:0]                 payload_len_o,
  output logic                        raise_stream_error_o,
  output logic [31:0]                 in_flight_o,
  output logic [7:0]                  retx_count_o,
  output logic                        last_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tswr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KW = tswr_pkg::SEG_CNT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [KW-1:0] MAX_K    = KW'(MAX_SEGMENTS_PER_PUSH);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] iseq_q, init_rto_q;
  logic [11:0] max_pay_q;
  logic [7:0]  max_retx_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iseq_q     <= tswr_pkg::INITIAL_SEQ_RST;
      init_rto_q <= tswr_pkg::INITIAL_RTO_RST;
      max_pay_q  <= tswr_pkg::SEG_SIZE_RST;
      max_retx_q <= tswr_pkg::MAX_RETX_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tswr_pkg::REG_INITIAL_SEQ: iseq_q     <= pwdata;
        tswr_pkg::REG_INITIAL_RTO: init_rto_q <= pwdata;
        tswr_pkg::REG_SEG_SIZE:    max_pay_q  <= pwdata[11:0];
        tswr_pkg::REG_MAX_RETX:    max_retx_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tswr_pkg::REG_INITIAL_SEQ: prdata = iseq_q;
      tswr_pkg::REG_INITIAL_RTO: prdata = init_rto_q;
      tswr_pkg::REG_SEG_SIZE:    prdata = {20'd0, max_pay_q};
      tswr_pkg::REG_MAX_RETX:    prdata = {24'd0, max_retx_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  tswr_pkg::state_e state_q, state_d;

  logic          syn_done_q, syn_done_d, fin_done_q, fin_done_d;
  logic          timer_on_q, timer_on_d;
  logic [63:0]   next_q, next_d;
  logic [31:0]   flight_q, flight_d;
  logic [15:0]   peer_win_q, peer_win_d;
  logic [31:0]   elapsed_q, elapsed_d;
  logic [31:0]   rto_q, rto_d;
  logic [7:0]    retx_q, retx_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  // per-item working registers
  logic [15:0]   eff_q, eff_d;
  logic [KW-1:0] k_q, k_d;
  logic [31:0]   rem_q, rem_d;
  logic [63:0]   ack_abs_q, ack_abs_d;
  logic          popped_q, popped_d, err_q, err_d;

  // latched command beat
  logic [1:0]  cmd_q;
  logic        closed_q, serr_q, present_q, rflag_q;
  logic [31:0] ackno_q, el_in_q;
  logic [15:0] win_in_q;

  tswr_pkg::result_t res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != tswr_pkg::ST_IDLE);

  // ---------------------------------------------------------------------
  // Queue memory; head is read every cycle, so data for the head entry is
  // ready in the cycle after head settles. Writes happen only during pushes,
  // when the read data is not used.
  // ---------------------------------------------------------------------
  logic             q_wr;
  tswr_pkg::entry_t q_wdata, q_rdata;

  tswr_queue #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_queue (
    .clk_i     (clk_i),
    .wr_en_i   (q_wr),
    .wr_addr_i (tail_q),
    .wr_data_i (q_wdata),
    .rd_addr_i (head_q),
    .rd_data_o (q_rdata)
  );

  // ---------------------------------------------------------------------
  // Shared datapath terms
  // ---------------------------------------------------------------------
  logic [15:0] window;
  logic        win_le_flight;
  logic        q_full;
  logic [11:0] take1, take;
  logic [31:0] rem_new;
  logic        seg_fin, seg_go, seg_emit;
  logic [31:0] ack_off, ack_d;
  logic [32:0] ack_back;
  logic [64:0] ack_diff;
  logic        ack_ok;
  logic [63:0] ack_abs;
  logic [63:0] q_end;
  logic        pop_ok;
  logic [32:0] el_sum;
  logic [31:0] el_sat;

  assign q_full        = (count_q == FULL_CNT);
  assign window        = (peer_win_q == 16'd0) ? 16'd1 : peer_win_q;
  assign win_le_flight = ({16'd0, window} <= flight_q);

  // segment cut: bounded by window, segment size limit and stream bytes
  assign take1    = (eff_q < {4'd0, max_pay_q}) ? eff_q[11:0] : max_pay_q;
  assign take     = (rem_q < {20'd0, take1}) ? rem_q[11:0] : take1;
  assign rem_new  = rem_q - {20'd0, take};
  assign seg_fin  = ({4'd0, take} < eff_q) && closed_q && (rem_new == 32'd0);
  assign seg_go   = (eff_q != 16'd0) && !fin_done_q && (k_q < MAX_K) && !q_full;
  assign seg_emit = (take != 12'd0) || seg_fin;

  // ackno unwrap; only values at or below next_q are kept
  assign ack_off  = ackno_q - iseq_q;
  assign ack_d    = ack_off - next_q[31:0];
  assign ack_back = 33'h1_0000_0000 - {1'b0, ack_d};
  assign ack_diff = {1'b0, next_q} - {32'd0, ack_back};
  assign ack_ok   = (ack_d == 32'd0) || (ack_d[31] && !ack_diff[64]);
  assign ack_abs  = (ack_d == 32'd0) ? next_q : ack_diff[63:0];

  assign q_end  = q_rdata.start + {51'd0, tswr_pkg::seq_len(q_rdata.desc)};
  assign pop_ok = (q_end <= ack_abs_q);

  assign el_sum = {1'b0, elapsed_q} + {1'b0, el_in_q};
  assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tswr_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            tswr_pkg::CMD_PUSH: state_d = tswr_pkg::ST_PUSH_INIT;
            tswr_pkg::CMD_ACK:  state_d = tswr_pkg::ST_ACK_CHECK;
            tswr_pkg::CMD_TICK: state_d = tswr_pkg::ST_TICK_ADD;
            default:            state_d = tswr_pkg::ST_STATUS;
          endcase
        end
      end
      tswr_pkg::ST_PUSH_INIT: begin
        if (!syn_done_q || win_le_flight) state_d = tswr_pkg::ST_STATUS;
        else                              state_d = tswr_pkg::ST_PUSH_SEG;
      end
      tswr_pkg::ST_PUSH_SEG: begin
        if (!seg_go || !seg_emit || seg_fin) state_d = tswr_pkg::ST_STATUS;
      end
      tswr_pkg::ST_ACK_CHECK: begin
        if (rflag_q || !present_q || !ack_ok) state_d = tswr_pkg::ST_STATUS;
        else                                  state_d = tswr_pkg::ST_POP_RD;
      end
      tswr_pkg::ST_POP_RD: begin
        if (count_q == '0) state_d = tswr_pkg::ST_ACK_DONE;
        else               state_d = tswr_pkg::ST_POP_CHK;
      end
      tswr_pkg::ST_POP_CHK: begin
        if (pop_ok) state_d = tswr_pkg::ST_POP_RD;
        else        state_d = tswr_pkg::ST_ACK_DONE;
      end
      tswr_pkg::ST_ACK_DONE: state_d = tswr_pkg::ST_STATUS;
      tswr_pkg::ST_TICK_ADD: begin
        if (timer_on_q) state_d = tswr_pkg::ST_TICK_CMP;
        else            state_d = tswr_pkg::ST_STATUS;
      end
      tswr_pkg::ST_TICK_CMP: begin
        if (elapsed_q < rto_q || retx_q > max_retx_q || count_q == '0) begin
          state_d = tswr_pkg::ST_STATUS;
        end else begin
          state_d = tswr_pkg::ST_TICK_SEND;
        end
      end
      tswr_pkg::ST_TICK_SEND: state_d = tswr_pkg::ST_STATUS;
      tswr_pkg::ST_STATUS:    state_d = tswr_pkg::ST_IDLE;
      default:                state_d = tswr_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and result beats
  // ---------------------------------------------------------------------
  logic            send_en;
  tswr_pkg::desc_t send_desc;
  logic [12:0]     send_n;

  always_comb begin
    send_en        = 1'b0;
    send_desc      = '0;
    if (state_q == tswr_pkg::ST_PUSH_INIT && !syn_done_q && !q_full) begin
      send_en       = 1'b1;
      send_desc.syn = 1'b1;
      send_desc.rst = serr_q;
      send_desc.fin = closed_q && (rem_q == 32'd0);
    end else if (state_q == tswr_pkg::ST_PUSH_SEG && seg_go && seg_emit) begin
      send_en       = 1'b1;
      send_desc.len = take;
      send_desc.fin = seg_fin;
      send_desc.rst = serr_q;
    end
  end

  assign send_n  = tswr_pkg::seq_len(send_desc);
  assign q_wr    = send_en;
  assign q_wdata = '{start: next_q, desc: send_desc};

  always_comb begin
    syn_done_d  = syn_done_q;
    fin_done_d  = fin_done_q;
    timer_on_d  = timer_on_q;
    next_d      = next_q;
    flight_d    = flight_q;
    peer_win_d  = peer_win_q;
    elapsed_d   = elapsed_q;
    rto_d       = rto_q;
    retx_d      = retx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    eff_d       = eff_q;
    k_d         = k_q;
    rem_d       = rem_q;
    ack_abs_d   = ack_abs_q;
    popped_d    = popped_q;
    err_d       = err_q;
    res_d       = res_q;
    res_valid_d = 1'b0;

    // new segment: enqueue, advance sequence space, arm the timer
    if (send_en) begin
      next_d   = next_q + {51'd0, send_n};
      flight_d = flight_q + {19'd0, send_n};
      tail_d   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
      count_d  = count_q + 1'b1;
      if (!timer_on_q) begin
        elapsed_d  = 32'd0;
        rto_d      = init_rto_q;
        timer_on_d = 1'b1;
      end
      res_valid_d = 1'b1;
      res_d       = '0;
      res_d.is_segment     = 1'b1;
      res_d.wire_seqno     = next_q[31:0] + iseq_q;
      res_d.absolute_seqno = next_q;
      res_d.syn_bit        = send_desc.syn;
      res_d.fin_bit        = send_desc.fin;
      res_d.rst_bit        = send_desc.rst;
      res_d.payload_len    = send_desc.len;
    end

    case (state_q)
      tswr_pkg::ST_IDLE: begin
        if (accept) begin
          err_d    = 1'b0;
          popped_d = 1'b0;
          k_d      = '0;
          rem_d    = bytes_available_i;
        end
      end
      tswr_pkg::ST_PUSH_INIT: begin
        if (!syn_done_q) begin
          if (!q_full) begin
            syn_done_d = 1'b1;
            if (send_desc.fin) fin_done_d = 1'b1;
          end
        end else begin
          eff_d = window - flight_q[15:0];
        end
      end
      tswr_pkg::ST_PUSH_SEG: begin
        if (seg_go && seg_emit) begin
          rem_d = rem_new;
          eff_d = eff_q - {4'd0, take} - {15'd0, seg_fin};
          k_d   = k_q + 1'b1;
          if (seg_fin) fin_done_d = 1'b1;
        end
      end
      tswr_pkg::ST_ACK_CHECK: begin
        if (rflag_q) begin
          err_d = 1'b1;
        end else if (present_q && ack_ok) begin
          ack_abs_d  = ack_abs;
          peer_win_d = win_in_q;
        end
      end
      tswr_pkg::ST_POP_CHK: begin
        // retire the head descriptor
        if (pop_ok) begin
          flight_d = flight_q - {19'd0, tswr_pkg::seq_len(q_rdata.desc)};
          head_d   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
          count_d  = count_q - 1'b1;
          popped_d = 1'b1;
        end
      end
      tswr_pkg::ST_ACK_DONE: begin
        if (popped_q) begin
          rto_d      = init_rto_q;
          retx_d     = 8'd0;
          elapsed_d  = 32'd0;
          timer_on_d = (count_q != '0);
        end
      end
      tswr_pkg::ST_TICK_ADD: begin
        if (timer_on_q) elapsed_d = el_sat;
      end
      tswr_pkg::ST_TICK_CMP: begin
        if (elapsed_q >= rto_q && (retx_q > max_retx_q || count_q == '0)) begin
          timer_on_d = 1'b0;
        end
      end
      tswr_pkg::ST_TICK_SEND: begin
        // resend the oldest outstanding descriptor; back off unless the
        // peer window is shut on a data segment
        res_valid_d = 1'b1;
        res_d       = '0;
        res_d.is_segment     = 1'b1;
        res_d.is_retransmit  = 1'b1;
        res_d.wire_seqno     = q_rdata.start[31:0] + iseq_q;
        res_d.absolute_seqno = q_rdata.start;
        res_d.syn_bit        = q_rdata.desc.syn;
        res_d.fin_bit        = q_rdata.desc.fin;
        res_d.rst_bit        = q_rdata.desc.rst;
        res_d.payload_len    = q_rdata.desc.len;
        if (q_rdata.desc.syn || peer_win_q != 16'd0) begin
          if (retx_q != 8'hFF) retx_d = retx_q + 1'b1;
          rto_d = rto_q[31] ? 32'hFFFF_FFFF : {rto_q[30:0], 1'b0};
        end
        elapsed_d = 32'd0;
      end
      tswr_pkg::ST_STATUS: begin
        res_valid_d = 1'b1;
        res_d       = '0;
        res_d.raise_stream_error = err_q;
        res_d.in_flight          = flight_q;
        res_d.retx_count         = retx_q;
        res_d.last               = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tswr_pkg::ST_IDLE;
      syn_done_q  <= 1'b0;
      fin_done_q  <= 1'b0;
      timer_on_q  <= 1'b0;
      next_q      <= 64'd0;
      flight_q    <= 32'd0;
      peer_win_q  <= 16'd1;
      elapsed_q   <= 32'd0;
      rto_q       <= tswr_pkg::INITIAL_RTO_RST;
      retx_q      <= 8'd0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      popped_q    <= 1'b0;
      err_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      syn_done_q  <= syn_done_d;
      fin_done_q  <= fin_done_d;
      timer_on_q  <= timer_on_d;
      next_q      <= next_d;
      flight_q    <= flight_d;
      peer_win_q  <= peer_win_d;
      elapsed_q   <= elapsed_d;
      rto_q       <= rto_d;
      retx_q      <= retx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      k_q         <= k_d;
      popped_q    <= popped_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers: hold the command beat and working values
  always_ff @(posedge clk_i) begin
    eff_q     <= eff_d;
    rem_q     <= rem_d;
    ack_abs_q <= ack_abs_d;
    res_q     <= res_d;
    if (accept) begin
      cmd_q     <= cmd_i;
      closed_q  <= stream_closed_i;
      serr_q    <= stream_error_i;
      present_q <= ack_present_i;
      ackno_q   <= ack_number_i;
      win_in_q  <= window_size_i;
      rflag_q   <= reset_flag_i;
      el_in_q   <= elapsed_ms_i;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign is_segment_o         = res_q.is_segment;
  assign is_retransmit_o      = res_q.is_retransmit;
  assign wire_seqno_o         = res_q.wire_seqno;
  assign absolute_seqno_o     = res_q.absolute_seqno;
  assign syn_bit_o            = res_q.syn_bit;
  assign fin_bit_o            = res_q.fin_bit;
  assign rst_bit_o            = res_q.rst_bit;
  assign payload_len_o        = res_q.payload_len;
  assign raise_stream_error_o = res_q.raise_stream_error;
  assign in_flight_o          = res_q.in_flight;
  assign retx_count_o         = res_q.retx_count;
  assign last_o               = res_q.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q)) else $error("empty queue with split pointers");

  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (result_valid_o && last_o)) else $error("item ended without status");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !is_segment_o) else $error("status beat flagged as segment");

  a_cmd_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> (cmd_q == tswr_pkg::CMD_PUSH)) else $error("queue write outside a push");

endmodule

// ===== rtl/tswr_queue.sv =====
// Descriptor queue storage: one write port, one read port, registered read.
// Depends on tswr_pkg for the entry type.
module tswr_queue #(
  parameter int unsigned DEPTH = tswr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  tswr_pkg::entry_t     wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output tswr_pkg::entry_t     rd_data_o
);

  tswr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for tcp_sender_window_retransmit.
// Drives push, ack and tick commands and configuration writes, predicts every result
// beat in SystemVerilog and compares it field by field. Depends on tswr_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int QDEPTH  = 64;
  localparam int SEG_CAP = 63;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] bytes;
    logic        closed;
    logic        serr;
    logic        ackp;
    logic [31:0] ackno;
    logic [15:0] win;
    logic        rflag;
    logic [31:0] elapsed;
  } command_t;

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic [1:0]  cmd_i;
  logic [31:0] bytes_available_i, ack_number_i, elapsed_ms_i;
  logic        stream_closed_i, stream_error_i, ack_present_i, reset_flag_i;
  logic [15:0] window_size_i;
  logic        result_valid_o, is_segment_o, is_retransmit_o;
  logic [31:0] wire_seqno_o, in_flight_o;
  logic [63:0] absolute_seqno_o;
  logic        syn_bit_o, fin_bit_o, rst_bit_o, raise_stream_error_o, last_o;
  logic [11:0] payload_len_o;
  logic [7:0]  retx_count_o;
  logic        psel, penable, pwrite, pready;
  logic [tswr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  tcp_sender_window_retransmit u_top (.*);

  // Mirror of the configuration registers
  logic [31:0] cfg_iseq, cfg_rto;
  logic [11:0] cfg_mss;
  logic [7:0]  cfg_max_retx;

  // Mirror of the sender state
  logic        syn_sent, fin_sent, timer_run;
  logic [63:0] next_seq;
  logic [31:0] flight, timer_ms, rto_ms;
  logic [15:0] peer_win;
  logic [7:0]  retx_run;
  logic [63:0] desc_start [QDEPTH];
  tswr_pkg::desc_t desc_flags [QDEPTH];
  int          q_head, q_tail, q_count;

  tswr_pkg::result_t pending_beats [$];
  int          errors, n_items, n_segments, n_resends, burst_left;
  bit          paced;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [63:0] span(tswr_pkg::desc_t d);
    return {52'd0, d.len} + d.syn + d.fin;
  endfunction

  function automatic void emit_segment(bit resend, logic [63:0] abs_seq, tswr_pkg::desc_t d);
    tswr_pkg::result_t r;
    r                = '0;
    r.is_segment     = 1'b1;
    r.is_retransmit  = resend;
    r.wire_seqno     = abs_seq[31:0] + cfg_iseq;
    r.absolute_seqno = abs_seq;
    r.syn_bit        = d.syn;
    r.fin_bit        = d.fin;
    r.rst_bit        = d.rst;
    r.payload_len    = d.len;
    pending_beats.push_back(r);
  endfunction

  // Transmit a new descriptor: emit it, queue it and arm the timer if idle
  function automatic void transmit(tswr_pkg::desc_t d);
    logic [63:0] n;
    n = span(d);
    emit_segment(1'b0, next_seq, d);
    desc_start[q_tail] = next_seq;
    desc_flags[q_tail] = d;
    q_tail   = (q_tail + 1) % QDEPTH;
    q_count++;
    next_seq = next_seq + n;
    flight   = flight + n[31:0];
    if (!timer_run) begin
      timer_ms  = '0;
      rto_ms    = cfg_rto;
      timer_run = 1'b1;
    end
  endfunction

  function automatic void model_push(command_t c);
    logic [63:0]     left, wnd, room, take;
    bit              fin;
    tswr_pkg::desc_t d;
    int              k;
    left = {32'd0, c.bytes};
    k    = 0;
    if (!syn_sent) begin
      if (q_count < QDEPTH) begin
        d     = '0;
        d.syn = 1'b1;
        d.rst = c.serr;
        if (c.closed && left == 0) begin
          d.fin    = 1'b1;
          fin_sent = 1'b1;
        end
        transmit(d);
        syn_sent = 1'b1;
      end
      return;
    end
    wnd = (peer_win == 0) ? 64'd1 : {48'd0, peer_win};
    if (wnd <= {32'd0, flight}) return;
    room = wnd - flight;
    while (room > 0 && !fin_sent && k < SEG_CAP && q_count < QDEPTH) begin
      take = (room < cfg_mss) ? room : {52'd0, cfg_mss};
      if (left < take) take = left;
      left = left - take;
      fin  = take < room && c.closed && left == 0;
      if (take == 0 && !fin) break;
      d     = '0;
      d.len = take[11:0];
      d.rst = c.serr;
      d.fin = fin;
      transmit(d);
      k++;
      room = room - take - fin;
      if (fin) begin
        fin_sent = 1'b1;
        break;
      end
    end
  endfunction

  // Unwrap to the absolute value nearest next_seq; ties go low when not negative
  function automatic logic [63:0] unwrap(logic [31:0] ackno);
    logic [31:0] gap;
    logic [63:0] back;
    gap  = ackno - cfg_iseq - next_seq[31:0];
    back = 64'h1_0000_0000 - gap;
    if (gap < 32'h8000_0000) return next_seq + gap;
    if (next_seq >= back) return next_seq - back;
    return next_seq + gap;
  endfunction

  function automatic bit model_ack(command_t c);
    logic [63:0] ack_abs;
    bit          retired;
    retired = 1'b0;
    if (c.rflag) return 1'b1;
    if (!c.ackp) return 1'b0;
    ack_abs = unwrap(c.ackno);
    if (ack_abs > next_seq) return 1'b0;
    peer_win = c.win;
    while (q_count > 0) begin
      if (desc_start[q_head] + span(desc_flags[q_head]) > ack_abs) break;
      flight  = flight - span(desc_flags[q_head]);
      q_head  = (q_head + 1) % QDEPTH;
      q_count--;
      retired = 1'b1;
    end
    if (retired) begin
      rto_ms    = cfg_rto;
      retx_run  = '0;
      timer_ms  = '0;
      timer_run = q_count > 0;
    end
    return 1'b0;
  endfunction

  function automatic void model_tick(command_t c);
    tswr_pkg::desc_t d;
    if (!timer_run) return;
    timer_ms = (timer_ms > 32'hFFFF_FFFF - c.elapsed) ? 32'hFFFF_FFFF : timer_ms + c.elapsed;
    if (timer_ms < rto_ms) return;
    if (retx_run > cfg_max_retx || q_count == 0) begin
      timer_run = 1'b0;
      return;
    end
    d = desc_flags[q_head];
    emit_segment(1'b1, desc_start[q_head], d);
    // back off only while the peer can take data, or for the SYN
    if (d.syn || peer_win > 0) begin
      if (retx_run != 8'hFF) retx_run++;
      rto_ms = (rto_ms > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {rto_ms[30:0], 1'b0};
    end
    timer_ms = '0;
  endfunction

  function automatic void predict_command(command_t c);
    tswr_pkg::result_t r;
    bit                err;
    err = 1'b0;
    case (c.cmd)
      tswr_pkg::CMD_PUSH: model_push(c);
      tswr_pkg::CMD_ACK:  err = model_ack(c);
      tswr_pkg::CMD_TICK: model_tick(c);
      default: ;
    endcase
    r                    = '0;
    r.raise_stream_error = err;
    r.in_flight          = flight;
    r.retx_count         = retx_run;
    r.last               = 1'b1;
    pending_beats.push_back(r);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 30)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    tswr_pkg::result_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_beats.size() == 0) begin
        report("beat with nothing expected", {63'd0, last_o}, 64'd0);
      end else begin
        w = pending_beats.pop_front();
        if (is_segment_o) n_segments++;
        if (is_retransmit_o) n_resends++;
        if (is_segment_o !== w.is_segment) report("is_segment", is_segment_o, w.is_segment);
        if (is_retransmit_o !== w.is_retransmit)
          report("is_retransmit", is_retransmit_o, w.is_retransmit);
        if (wire_seqno_o !== w.wire_seqno) report("wire_seqno", wire_seqno_o, w.wire_seqno);
        if (absolute_seqno_o !== w.absolute_seqno)
          report("absolute_seqno", absolute_seqno_o, w.absolute_seqno);
        if (syn_bit_o !== w.syn_bit) report("syn_bit", syn_bit_o, w.syn_bit);
        if (fin_bit_o !== w.fin_bit) report("fin_bit", fin_bit_o, w.fin_bit);
        if (rst_bit_o !== w.rst_bit) report("rst_bit", rst_bit_o, w.rst_bit);
        if (payload_len_o !== w.payload_len) report("payload_len", payload_len_o, w.payload_len);
        if (raise_stream_error_o !== w.raise_stream_error)
          report("raise_stream_error", raise_stream_error_o, w.raise_stream_error);
        if (in_flight_o !== w.in_flight) report("in_flight", in_flight_o, w.in_flight);
        if (retx_count_o !== w.retx_count) report("retx_count", retx_count_o, w.retx_count);
        if (last_o !== w.last) report("last", last_o, w.last);
      end
    end
  end

  // Send one command beat; hold start until the block takes it
  task automatic send(command_t c);
    if (paced && burst_left == 0) begin
      @(negedge clk_i) start_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    start_i           = 1'b1;
    cmd_i             = c.cmd;
    bytes_available_i = c.bytes;
    stream_closed_i   = c.closed;
    stream_error_i    = c.serr;
    ack_present_i     = c.ackp;
    ack_number_i      = c.ackno;
    window_size_i     = c.win;
    reset_flag_i      = c.rflag;
    elapsed_ms_i      = c.elapsed;
    do @(posedge clk_i); while (busy_o);
    predict_command(c);
    n_items++;
    if (burst_left > 0) burst_left--;
  endtask

  // Drop start and wait until every expected beat has come
  task automatic drain();
    @(negedge clk_i) start_i = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random content in the fields the command does not use
  function automatic command_t noise(logic [1:0] op);
    command_t c;
    c.cmd     = op;
    c.bytes   = $urandom;
    c.closed  = 1'($urandom_range(0, 1));
    c.serr    = 1'($urandom_range(0, 1));
    c.ackp    = 1'($urandom_range(0, 1));
    c.ackno   = $urandom;
    c.win     = 16'($urandom);
    c.rflag   = 1'($urandom_range(0, 1));
    c.elapsed = $urandom;
    return c;
  endfunction

  task automatic do_push(logic [31:0] bytes, bit closed, bit serr);
    command_t c;
    c        = noise(tswr_pkg::CMD_PUSH);
    c.bytes  = bytes;
    c.closed = closed;
    c.serr   = serr;
    send(c);
  endtask

  task automatic do_ack(logic [63:0] ack_abs, logic [15:0] win, bit present, bit rflag);
    command_t c;
    c       = noise(tswr_pkg::CMD_ACK);
    c.ackno = ack_abs[31:0] + cfg_iseq;
    c.win   = win;
    c.ackp  = present;
    c.rflag = rflag;
    send(c);
  endtask

  task automatic do_tick(logic [31:0] ms);
    command_t c;
    c         = noise(tswr_pkg::CMD_TICK);
    c.elapsed = ms;
    send(c);
  endtask

  // Write one register through a setup phase and an access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      tswr_pkg::REG_INITIAL_SEQ: cfg_iseq     = value;
      tswr_pkg::REG_INITIAL_RTO: cfg_rto      = value;
      tswr_pkg::REG_SEG_SIZE:    cfg_mss      = value[11:0];
      tswr_pkg::REG_MAX_RETX:    cfg_max_retx = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(logic [31:0] iseq, logic [31:0] rto, logic [11:0] mss,
                           logic [7:0] mretx);
    drain();
    write_reg(tswr_pkg::REG_INITIAL_SEQ, iseq);
    write_reg(tswr_pkg::REG_INITIAL_RTO, rto);
    write_reg(tswr_pkg::REG_SEG_SIZE, {20'd0, mss});
    write_reg(tswr_pkg::REG_MAX_RETX, {24'd0, mretx});
  endtask

  // Opening: idle commands, SYN, its timer, zero window and the first data
  task automatic test_handshake();
    command_t c;
    do_tick(32'd5000);                       // timer idle: status only
    c = noise(2'd3);
    send(c);                                 // unknown command
    do_ack(64'd0, 16'd0, 1'b1, 1'b1);        // peer RST
    do_ack(64'd0, 16'd0, 1'b0, 1'b0);        // no ackno
    do_push(32'd0, 1'b0, 1'b0);              // SYN on an open stream
    do_push(32'd100, 1'b0, 1'b0);            // window 1 full with SYN
    do_tick(32'd999);
    do_tick(32'd1);                          // expiry: resend SYN
    do_ack(next_seq + 5, 16'd0, 1'b1, 1'b0); // ackno ahead: ignored
    do_ack(next_seq + 64'h8000_0000, 16'd0, 1'b1, 1'b0); // halfway tie
    do_ack(next_seq, 16'd0, 1'b1, 1'b0);     // SYN acked, zero window
    do_push(32'd50, 1'b0, 1'b0);             // zero window taken as one
    do_tick(32'd1000);                       // resend, no back-off
    do_tick(32'hFFFF_FFFF);
    do_ack(next_seq, 16'hFFFF, 1'b1, 1'b0);
    do_push(32'd5000, 1'b0, 1'b1);           // RST flags on data
    do_push(32'hFFFF_FFFF, 1'b0, 1'b0);      // queue fills before the window
    do_ack(next_seq - 1000, 16'hFFFF, 1'b1, 1'b0);
    do_ack(next_seq, 16'hFFFF, 1'b1, 1'b0);
  endtask

  // Queue full, saturating timeout and an exhausted retry budget
  task automatic test_limits();
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 12'd1, 8'd0);
    do_push(32'hFFFF_FFFF, 1'b0, 1'b0);      // 63 segments
    do_push(32'hFFFF_FFFF, 1'b0, 1'b0);      // one more fills the queue
    do_push(32'hFFFF_FFFF, 1'b0, 1'b0);      // queue full: nothing
    do_tick(32'hFFFF_FFFF);                  // resend, timeout saturated
    do_tick(32'hFFFF_FFFF);                  // retry budget spent: timer stops
    do_tick(32'hFFFF_FFFF);
    do_ack(next_seq - 10, 16'd4000, 1'b1, 1'b0);
    do_ack(next_seq, 16'd4000, 1'b1, 1'b0);
    configure(32'd0, 32'd1, 12'd4095, 8'd255);
    do_push(32'd9000, 1'b0, 1'b0);
    repeat (4) do_tick(32'd0);
    do_tick(32'd1);
    do_ack(next_seq, 16'hFFFF, 1'b1, 1'b0);
  endtask

  task automatic random_phase(int count);
    command_t    c;
    int          pick, idx;
    logic [63:0] a;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        c       = noise(tswr_pkg::CMD_PUSH);
        c.bytes = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3 * cfg_mss + 5);
        c.closed = ($urandom_range(0, 150) == 0);
        c.serr   = ($urandom_range(0, 15) == 0);
      end else if (pick < 75) begin
        c       = noise(tswr_pkg::CMD_ACK);
        c.rflag = ($urandom_range(0, 30) == 0);
        c.ackp  = ($urandom_range(0, 20) != 0);
        a       = next_seq;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: a = next_seq;
          4, 5, 6: if (q_count > 0) begin
            idx = (q_head + $urandom_range(0, q_count - 1)) % QDEPTH;
            a   = desc_start[idx] + span(desc_flags[idx]);
          end
          7: a = next_seq + $urandom_range(1, 100);
          default: a = {32'd0, $urandom};
        endcase
        c.ackno = a[31:0] + cfg_iseq;
        case ($urandom_range(0, 9))
          0: c.win = 16'd0;
          1: c.win = 16'hFFFF;
          2: c.win = 16'($urandom);
          default: c.win = 16'($urandom_range(0, 5000));
        endcase
      end else if (pick < 95) begin
        c         = noise(tswr_pkg::CMD_TICK);
        c.elapsed = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2500);
      end else begin
        c = noise(2'd3);
      end
      send(c);
    end
  endtask

  task automatic test_random();
    paced = 1'b1;
    random_phase(90);
    configure($urandom, 32'd1000, 12'd1, 8'd0);
    random_phase(90);
    configure(32'hFFFF_FFFF, 32'd1, 12'd4095, 8'd255);
    paced = 1'b0;                             // back-to-back stretch
    random_phase(60);
    paced = 1'b1;
    random_phase(30);
    drain();                                  // sender holds off until all beats are in
    configure($urandom, $urandom_range(1, 3000), 12'($urandom_range(1, 2000)),
              8'($urandom_range(0, 255)));
    random_phase(90);
    configure($urandom, 32'd1000, 12'd1000, 8'd8);
    random_phase(90);
  endtask

  // Zero payload size: only the FIN can go out
  task automatic test_fin_only();
    configure(cfg_iseq, 32'd1000, 12'd0, 8'd3);
    do_ack(next_seq, 16'd3000, 1'b1, 1'b0);
    do_push(32'd0, 1'b1, 1'b0);
    do_push(32'd500, 1'b1, 1'b0);
    repeat (6) do_tick(32'd4000);
    do_ack(next_seq, 16'd3000, 1'b1, 1'b0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = tswr_pkg::CMD_PUSH;
    bytes_available_i = '0;
    stream_closed_i = 1'b0;
    stream_error_i = 1'b0;
    ack_present_i = 1'b0;
    ack_number_i = '0;
    window_size_i = '0;
    reset_flag_i = 1'b0;
    elapsed_ms_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_iseq = tswr_pkg::INITIAL_SEQ_RST;
    cfg_rto = tswr_pkg::INITIAL_RTO_RST;
    cfg_mss = tswr_pkg::SEG_SIZE_RST;
    cfg_max_retx = tswr_pkg::MAX_RETX_RST;
    syn_sent = 1'b0;
    fin_sent = 1'b0;
    timer_run = 1'b0;
    next_seq = '0;
    flight = '0;
    timer_ms = '0;
    rto_ms = tswr_pkg::INITIAL_RTO_RST;
    peer_win = 16'd1;
    retx_run = '0;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    errors = 0;
    n_items = 0;
    n_segments = 0;
    n_resends = 0;
    burst_left = 0;
    paced = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    test_handshake();
    test_limits();
    test_random();
    test_fin_only();
    drain();

    $display("summary: %0d commands, %0d segments of which %0d resent, %0d errors",
             n_items, n_segments, n_resends, errors);
    $display("covered: SYN, zero window, full queue, capped push, timer back-off, FIN");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
